// ===== src/rud_pkg.sv =====
package rud_pkg;

  // Operand width; also the number of pipeline stages (one quotient bit each)
  localparam int WIDTH = 32;

  typedef struct packed {
    logic [WIDTH-1:0] rem;  // partial remainder
    logic [WIDTH-1:0] qd;   // dividend bits still to shift in (top), quotient bits (bottom)
    logic [WIDTH-1:0] den;
    logic             dbz;
  } rud_stage_t;

endpackage

// ===== src/rud_channels.sv =====
interface rud_in_if;
  logic                     valid;
  logic                     ready;
  logic [rud_pkg::WIDTH-1:0] dividend;
  logic [rud_pkg::WIDTH-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface rud_out_if;
  logic                     valid;
  logic                     ready;
  logic [rud_pkg::WIDTH-1:0] quotient;
  logic [rud_pkg::WIDTH-1:0] remainder;
  logic                     div_by_zero;

  modport source (output valid, output quotient, output remainder, output div_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input div_by_zero,
                  output ready);
endinterface

// ===== src/restoring_unsigned_divider_top.sv =====
// Pipelined restoring divider for unsigned operands: accepts one dividend/divisor
// transfer every cycle and returns quotient and remainder, one result per cycle,
// both while the output is not stalled. Each of the 32 register stages resolves
// one quotient bit with a single shift, compare and subtract; the last stage
// register is the output register. While a result waits at the output the whole
// pipeline holds, so in_ch.ready follows out_ch.ready combinationally. A zero
// divisor returns all ones in quotient and remainder and raises div_by_zero.
module restoring_unsigned_divider_top (
  input  logic      clk,
  input  logic      rst_n,
  rud_in_if.sink    in_ch,
  rud_out_if.source out_ch
);

  localparam int W = rud_pkg::WIDTH;

  logic [W:0]          v;
  rud_pkg::rud_stage_t d [0:W];
  logic                advance;

  assign advance     = ~v[W] | out_ch.ready;
  assign in_ch.ready = advance;

  assign v[0]     = in_ch.valid;
  assign d[0].rem = '0;
  assign d[0].qd  = in_ch.dividend;
  assign d[0].den = in_ch.divisor;
  assign d[0].dbz = (in_ch.divisor == '0);

  for (genvar k = 0; k < W; k++) begin : g_stage
    rud_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (advance),
      .valid_i (v[k]),
      .data_i  (d[k]),
      .valid_o (v[k+1]),
      .data_o  (d[k+1])
    );
  end

  assign out_ch.valid       = v[W];
  assign out_ch.quotient    = d[W].dbz ? '1 : d[W].qd;
  assign out_ch.remainder   = d[W].dbz ? '1 : d[W].rem;
  assign out_ch.div_by_zero = d[W].dbz;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (v[W] && !d[W].dbz) |-> (d[W].rem < d[W].den))
    else $error("final remainder not below divisor");

  a_first_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (v[1] == $past(in_ch.valid)))
    else $error("first stage valid does not follow accepted transfer");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(v[W:1]) && $stable(d[W])))
    else $error("pipeline moved during output stall");

endmodule

// ===== src/rud_stage.sv =====
module rud_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                valid_i,
  input  rud_pkg::rud_stage_t data_i,
  output logic                valid_o,
  output rud_pkg::rud_stage_t data_o
);

  logic                        valid_r;
  rud_pkg::rud_stage_t         data_r;
  rud_pkg::rud_stage_t         data_nxt;
  logic [rud_pkg::WIDTH-1:0]   shifted;
  logic [rud_pkg::WIDTH+1:0]   diff;
  logic                        ge;

  // Shift next dividend bit into the remainder; bit shifted out of the top
  // joins the compare, so the subtract is carried out on WIDTH+2 bits.
  always_comb begin
    shifted = {data_i.rem[rud_pkg::WIDTH-2:0], data_i.qd[rud_pkg::WIDTH-1]};
    diff    = {1'b0, data_i.rem[rud_pkg::WIDTH-1], shifted} - {2'b00, data_i.den};
    ge      = ~diff[rud_pkg::WIDTH+1];
    data_nxt.rem = ge ? diff[rud_pkg::WIDTH-1:0] : shifted;
    data_nxt.qd  = {data_i.qd[rud_pkg::WIDTH-2:0], ge};
    data_nxt.den = data_i.den;
    data_nxt.dbz = data_i.dbz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule
